[rtl/core/assert_macros.svh]
// Assertion macros shared by the owner registry table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a boolean property at every clock edge outside reset.
`define ORTS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("owner registry table: assertion failed");

// Checks that an antecedent implies a consequent in the same cycle.
`define ORTS_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owner registry table: implication failed");

`endif

[rtl/core/orts_pkg.sv]
// Package with types, codes and constants of the owner registry table.
package orts_pkg;

  localparam int ID_W         = 16;
  localparam int SLOT_FIELD_W = 3;
  localparam int COUNT_W      = 4;
  localparam int SLOTS_DEF    = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_ARG      = 3'd1,
    ST_DUP_OWNER    = 3'd2,
    ST_DUP_INSTANCE = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t         opcode;
    logic [ID_W-1:0] owner_id;
    logic [ID_W-1:0] instance_id;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot_used;
    logic [COUNT_W-1:0]      removed_count;
  } rsp_t;

  // Request token that walks the cell chain, gathering the scan results.
  typedef struct packed {
    logic               valid;
    opcode_t            opcode;
    logic [ID_W-1:0]    owner_id;
    logic [ID_W-1:0]    instance_id;
    logic               dup_owner;
    logic               dup_inst;
    logic               have_free;
    logic [COUNT_W-1:0] removed_count;
  } scan_t;

  // Write broadcast to the cell that claimed the lowest free slot.
  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] owner_id;
    logic [ID_W-1:0] instance_id;
  } commit_t;

endpackage

[rtl/core/orts_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface orts_req_if
  import orts_pkg::*;
();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface orts_rsp_if
  import orts_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/orts_cell.sv]
// One slot of the table: stores an owner/instance pair and checks passing requests.
module orts_cell
  import orts_pkg::*;
#(
  parameter int               IDX_W = 3,
  parameter logic [IDX_W-1:0] INDEX = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  scan_t            scan_in,
  input  logic [IDX_W-1:0] free_in,
  input  commit_t          commit,
  output scan_t            scan_out,
  output logic [IDX_W-1:0] free_out
);

  logic [ID_W-1:0]  owner_r, owner_nxt;
  logic [ID_W-1:0]  inst_r, inst_nxt;
  logic             pending_r, pending_nxt;
  scan_t            scan_r, scan_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic             slot_free;
  logic             owner_hit;

  assign slot_free = (inst_r == '0);
  assign owner_hit = (owner_r == scan_in.owner_id);

  always_comb begin
    scan_nxt    = scan_in;
    free_nxt    = free_in;
    owner_nxt   = owner_r;
    inst_nxt    = inst_r;
    pending_nxt = pending_r;
    if (scan_in.valid) begin
      if (scan_in.opcode == OP_REMOVE) begin
        pending_nxt = 1'b0;
        if ((scan_in.owner_id != '0) && owner_hit) begin
          owner_nxt = '0;
          inst_nxt  = '0;
          if (scan_in.removed_count != COUNT_MAX) begin
            scan_nxt.removed_count = scan_in.removed_count + COUNT_W'(1);
          end
        end
      end else begin
        // This cell claims the slot if it is the first free one seen so far.
        pending_nxt = slot_free && !scan_in.have_free;
        if (slot_free) begin
          if (!scan_in.have_free) begin
            scan_nxt.have_free = 1'b1;
            free_nxt           = INDEX;
          end
        end else begin
          if (owner_hit) begin
            scan_nxt.dup_owner = 1'b1;
          end
          if (inst_r == scan_in.instance_id) begin
            scan_nxt.dup_inst = 1'b1;
          end
        end
      end
    end
    if (commit.we && pending_r) begin
      owner_nxt = commit.owner_id;
      inst_nxt  = commit.instance_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r   <= '0;
      inst_r    <= '0;
      pending_r <= 1'b0;
      scan_r    <= '0;
    end else begin
      owner_r   <= owner_nxt;
      inst_r    <= inst_nxt;
      pending_r <= pending_nxt;
      scan_r    <= scan_nxt;
    end
    free_r <= free_nxt;
  end

  assign scan_out = scan_r;
  assign free_out = free_r;

endmodule

[rtl/core/owner_registry_table_top.sv]
// Top level of the owner registry table: cell chain, result register and handshakes.
//
// The block keeps a table of SLOTS slots, each pairing a 16-bit owner id
// with a 16-bit instance id, where zero means null. Requests arrive as words
// on the in_req channel and each one yields exactly one word on out_rsp.
// An add stores the pair in the lowest slot whose instance is null unless
// an id is null, the owner or instance already sits in an occupied slot, or
// no slot is free. A remove clears every slot holding the owner and returns
// how many it cleared, saturating at 15.
// A request word travels down a chain of SLOTS cells, one cell per cycle,
// so the scan through the cells sets the timing. A new request is taken
// only after the previous word has left the chain and its response has
// moved on to the output register. A finished response waits in a
// holding register, so the block takes the next request while the
// previous response is still on the output.
// Synchronous reset empties every slot and drops all words in flight.
// When the receiver stalls, one further response is held internally and
// requests are refused until it can move to the output register.
module owner_registry_table_top
  import orts_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  orts_req_if.sink   in_req,
  orts_rsp_if.source out_rsp
);

  `include "assert_macros.svh"

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Position k of the chain feeds cell k; the last position is the tail.
  scan_t            scan_chain [SLOTS+1];
  logic [IDX_W-1:0] free_chain [SLOTS+1];
  logic [SLOTS-1:0] tok_vld;
  commit_t          commit;
  scan_t            tail;
  scan_t            scan_head;

  logic busy_r, busy_nxt;
  logic pend_valid_r, pend_valid_nxt;
  rsp_t pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_r;
  rsp_t result;
  logic accept;
  logic move_out;

  assign in_req.ready = !busy_r && !pend_valid_r;
  assign accept       = in_req.valid && in_req.ready;

  // The accepted word enters the first cell directly.
  always_comb begin
    scan_head               = '0;
    scan_head.valid         = accept;
    scan_head.opcode        = in_req.data.opcode;
    scan_head.owner_id      = in_req.data.owner_id;
    scan_head.instance_id   = in_req.data.instance_id;
  end
  assign scan_chain[0] = scan_head;
  assign free_chain[0] = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    orts_cell #(
      .IDX_W (IDX_W),
      .INDEX (IDX_W'(k))
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .scan_in  (scan_chain[k]),
      .free_in  (free_chain[k]),
      .commit   (commit),
      .scan_out (scan_chain[k+1]),
      .free_out (free_chain[k+1])
    );
    assign tok_vld[k] = scan_chain[k+1].valid;
  end

  assign tail = scan_chain[SLOTS];

  // Decide the outcome once the word has seen every slot. A successful add
  // writes the slot claimed during the scan in this same cycle.
  always_comb begin
    result    = '0;
    commit    = '0;
    commit.owner_id    = tail.owner_id;
    commit.instance_id = tail.instance_id;
    if (tail.opcode == OP_REMOVE) begin
      result.status        = ST_OK;
      result.removed_count = tail.removed_count;
    end else if ((tail.owner_id == '0) || (tail.instance_id == '0)) begin
      result.status = ST_BAD_ARG;
    end else if (tail.dup_owner) begin
      result.status = ST_DUP_OWNER;
    end else if (tail.dup_inst) begin
      result.status = ST_DUP_INSTANCE;
    end else if (!tail.have_free) begin
      result.status = ST_FULL;
    end else begin
      result.status    = ST_OK;
      result.slot_used = SLOT_FIELD_W'(free_chain[SLOTS]);
      commit.we        = tail.valid;
    end
  end

  assign move_out = pend_valid_r && (!out_valid_r || out_rsp.ready);

  always_comb begin
    busy_nxt       = busy_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (tail.valid) begin
      busy_nxt       = 1'b0;
      pend_valid_nxt = 1'b1;
      pend_nxt       = result;
    end else if (move_out) begin
      pend_valid_nxt = 1'b0;
    end
    if (move_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_r <= pend_nxt;
    if (move_out) begin
      out_r <= pend_r;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_r;

  // Only one request word may be inside the cell chain at any time.
  `ORTS_ASSERT(a_single_token, $countones(tok_vld) <= 1)
  // A held response means the scan has finished.
  `ORTS_ASSERT_IMPLY(a_pend_not_busy, pend_valid_r, !busy_r)
  // A response appears only after a word left the end of the chain.
  `ORTS_ASSERT_IMPLY(a_pend_from_tail, $rose(pend_valid_r), $past(tail.valid))

endmodule
